[hw/rtl/pbm_pkg.sv]
`timescale 1ns / 1ps

package pbm_pkg;

    // Channel format: unsigned fixed point, 4096 is 1.0
    localparam int unsigned CH_W    = 13;
    localparam int unsigned FRAC_W  = 12;
    localparam int unsigned NUM_CH  = 4;
    localparam int unsigned ALPHA_CH = 3;
    localparam logic [CH_W-1:0] CH_ONE = 13'd4096;
    localparam logic [CH_W-1:0] CH_MAX = 13'd8191;

    // Mode codes on the func field; unlisted codes behave as replace
    localparam logic [3:0] FUNC_REPLACE  = 4'd0;
    localparam logic [3:0] FUNC_IGNORE   = 4'd1;
    localparam logic [3:0] FUNC_ADD      = 4'd2;
    localparam logic [3:0] FUNC_SUBTRACT = 4'd3;
    localparam logic [3:0] FUNC_MULTIPLY = 4'd4;
    localparam logic [3:0] FUNC_MORPH    = 4'd5;
    localparam logic [3:0] FUNC_BLEND    = 4'd6;
    localparam logic [3:0] FUNC_INVERT   = 4'd7;
    localparam logic [3:0] FUNC_MIN      = 4'd8;
    localparam logic [3:0] FUNC_MAX      = 4'd9;

    // How the last stage forms a channel result
    typedef enum logic [1:0] {
        OP_DIRECT = 2'd0,   // result computed in the first stage
        OP_SCALE  = 2'd1,   // trunc(product / 4096)
        OP_MIX    = 2'd2,   // base + trunc(product / 4096)
        OP_INV    = 2'd3    // trunc((4096 * sum - 2 * product) / 4096)
    } op_kind_t;

endpackage

[hw/rtl/pixel_blend_mode_unit.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_func, s_base_*, s_blend_* (13 bits each)
// m_        out        m_valid / m_ready  m_out_red/green/blue/alpha (13 bits each)
//
// Three register stages: operand select, multiply, normalize and clamp.
// One pixel is accepted every cycle while m_ready does not stall the output.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// close up and the input is taken while a result waits at the output.
// aresetn (synchronous, active low) clears the stage valid bits only.

module pixel_blend_mode_unit (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [3:0]               s_func,
    input  logic [pbm_pkg::CH_W-1:0] s_base_red,
    input  logic [pbm_pkg::CH_W-1:0] s_base_green,
    input  logic [pbm_pkg::CH_W-1:0] s_base_blue,
    input  logic [pbm_pkg::CH_W-1:0] s_base_alpha,
    input  logic [pbm_pkg::CH_W-1:0] s_blend_red,
    input  logic [pbm_pkg::CH_W-1:0] s_blend_green,
    input  logic [pbm_pkg::CH_W-1:0] s_blend_blue,
    input  logic [pbm_pkg::CH_W-1:0] s_blend_alpha,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [pbm_pkg::CH_W-1:0] m_out_red,
    output logic [pbm_pkg::CH_W-1:0] m_out_green,
    output logic [pbm_pkg::CH_W-1:0] m_out_blue,
    output logic [pbm_pkg::CH_W-1:0] m_out_alpha
);

    import pbm_pkg::*;

    logic a_valid_reg, b_valid_reg, c_valid_reg;
    logic en_a, en_b, en_c;

    logic [NUM_CH-1:0][CH_W-1:0] base_ch;
    logic [NUM_CH-1:0][CH_W-1:0] blend_ch;
    logic [NUM_CH-1:0][CH_W-1:0] result_reg;

    // Stage enables: load when empty or when the downstream stage moves
    assign en_c    = !c_valid_reg || m_ready;
    assign en_b    = !b_valid_reg || en_c;
    assign en_a    = !a_valid_reg || en_b;
    assign s_ready = en_a;
    assign m_valid = c_valid_reg;

    assign base_ch  = {s_base_alpha, s_base_blue, s_base_green, s_base_red};
    assign blend_ch = {s_blend_alpha, s_blend_blue, s_blend_green, s_blend_red};

    // Advance valid bits with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (en_a) begin
                a_valid_reg <= s_valid;
            end
            if (en_b) begin
                b_valid_reg <= a_valid_reg;
            end
            if (en_c) begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
        logic [CH_W-1:0]         x;
        logic [CH_W-1:0]         y;
        logic signed [CH_W:0]    diff;
        logic signed [CH_W:0]    diff_half;
        logic [CH_W:0]           sum;
        logic                    is_alpha;
        op_kind_t                kind_next;
        logic [CH_W-1:0]         direct_next;
        logic [CH_W:0]           addend_next;
        logic signed [CH_W:0]    op_a_next;
        logic signed [CH_W:0]    op_b_next;

        op_kind_t                a_kind_reg;
        logic [CH_W-1:0]         a_direct_reg;
        logic [CH_W:0]           a_addend_reg;
        logic signed [CH_W:0]    a_op_a_reg;
        logic signed [CH_W:0]    a_op_b_reg;

        op_kind_t                b_kind_reg;
        logic [CH_W-1:0]         b_direct_reg;
        logic [CH_W:0]           b_addend_reg;
        logic signed [2*CH_W+1:0] b_prod_reg;

        logic signed [2*CH_W+2:0] numer;
        logic signed [2*CH_W+2:0] numer_adj;
        logic signed [CH_W+3:0]   quot;
        logic signed [CH_W+4:0]   total;
        logic [CH_W-1:0]          result_next;

        assign x        = base_ch[ch];
        assign y        = blend_ch[ch];
        assign is_alpha = (ch == ALPHA_CH);
        assign diff     = $signed({1'b0, y}) - $signed({1'b0, x});
        // Half of the difference, rounded toward zero
        assign diff_half = diff[CH_W] ? ((diff + 14'sd1) >>> 1) : (diff >>> 1);
        assign sum       = {1'b0, x} + {1'b0, y};

        // Decode the mode into an operation for this channel
        always_comb begin
            kind_next   = OP_DIRECT;
            direct_next = y;
            addend_next = '0;
            op_a_next   = $signed({1'b0, x});
            op_b_next   = $signed({1'b0, y});
            unique case (s_func)
                FUNC_IGNORE: begin
                    direct_next = x;
                end
                FUNC_ADD: begin
                    direct_next = (sum > {1'b0, CH_ONE}) ? CH_ONE : sum[CH_W-1:0];
                end
                FUNC_SUBTRACT: begin
                    direct_next = (x >= y) ? (x - y) : '0;
                end
                FUNC_MULTIPLY: begin
                    kind_next = OP_SCALE;
                end
                FUNC_MORPH: begin
                    direct_next = x + diff_half[CH_W-1:0];
                end
                FUNC_BLEND: begin
                    if (is_alpha) begin
                        direct_next = x;
                    end else begin
                        kind_next   = OP_MIX;
                        addend_next = {1'b0, x};
                        op_a_next   = diff;
                        op_b_next   = $signed({1'b0, s_blend_alpha});
                    end
                end
                FUNC_INVERT: begin
                    if (is_alpha) begin
                        direct_next = x;
                    end else begin
                        kind_next   = OP_INV;
                        addend_next = {1'b0, x} + {1'b0, s_blend_alpha};
                        op_b_next   = $signed({1'b0, s_blend_alpha});
                    end
                end
                FUNC_MIN: begin
                    direct_next = (x < y) ? x : y;
                end
                FUNC_MAX: begin
                    direct_next = (x > y) ? x : y;
                end
                default: begin
                    direct_next = y;
                end
            endcase
        end

        // Stage A: hold selected operands
        always_ff @(posedge aclk) begin
            if (en_a && s_valid) begin
                a_kind_reg   <= kind_next;
                a_direct_reg <= direct_next;
                a_addend_reg <= addend_next;
                a_op_a_reg   <= op_a_next;
                a_op_b_reg   <= op_b_next;
            end
        end

        // Stage B: multiply
        always_ff @(posedge aclk) begin
            if (en_b && a_valid_reg) begin
                b_kind_reg   <= a_kind_reg;
                b_direct_reg <= a_direct_reg;
                b_addend_reg <= a_addend_reg;
                b_prod_reg   <= a_op_a_reg * a_op_b_reg;
            end
        end

        // Normalize by 4096 rounding toward zero, then clamp to the field
        assign numer = (b_kind_reg == OP_INV)
                     ? ($signed({3'b000, b_addend_reg, {FRAC_W{1'b0}}})
                        - $signed({b_prod_reg, 1'b0}))
                     : $signed({b_prod_reg[2*CH_W+1], b_prod_reg});
        assign numer_adj = numer[2*CH_W+2]
                         ? (numer + $signed({{(2*CH_W+3-FRAC_W){1'b0}}, {FRAC_W{1'b1}}}))
                         : numer;
        assign quot  = numer_adj[2*CH_W+2:FRAC_W];
        assign total = $signed({quot[CH_W+3], quot})
                     + ((b_kind_reg == OP_MIX) ? $signed({4'b0000, b_addend_reg})
                                               : $signed({(CH_W+5){1'b0}}));

        always_comb begin
            if (b_kind_reg == OP_DIRECT) begin
                result_next = b_direct_reg;
            end else if (total[CH_W+4]) begin
                result_next = '0;
            end else if (total[CH_W+3:CH_W] != '0) begin
                result_next = CH_MAX;
            end else begin
                result_next = total[CH_W-1:0];
            end
        end

        // Stage C: output register
        always_ff @(posedge aclk) begin
            if (en_c && b_valid_reg) begin
                result_reg[ch] <= result_next;
            end
        end
    end

    assign m_out_red   = result_reg[0];
    assign m_out_green = result_reg[1];
    assign m_out_blue  = result_reg[2];
    assign m_out_alpha = result_reg[3];

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import pbm_pkg::*;

    typedef logic [NUM_CH-1:0][CH_W-1:0] color_t;

    typedef struct packed {
        logic [3:0] func;
        color_t     base;
        color_t     blend;
    } pixel_t;

    typedef struct packed {
        pixel_t pix;
        logic   has_want;
        color_t want;
    } blend_case_t;

    localparam int     CH_RED      = 0;
    localparam int     CH_GREEN    = 1;
    localparam int     CH_BLUE     = 2;
    localparam longint FX_ONE      = 4096;
    localparam longint FX_HALF     = 2048;
    localparam longint FX_TOP      = 8191;
    localparam int     RAND_PIXELS = 1700;
    localparam int     CYCLE_LIMIT = 200000;

    logic         aclk;
    logic         aresetn       = 1'b0;
    logic         s_valid       = 1'b0;
    logic         s_ready;
    logic [3:0]   s_func        = '0;
    logic [CH_W-1:0] s_base_red    = '0;
    logic [CH_W-1:0] s_base_green  = '0;
    logic [CH_W-1:0] s_base_blue   = '0;
    logic [CH_W-1:0] s_base_alpha  = '0;
    logic [CH_W-1:0] s_blend_red   = '0;
    logic [CH_W-1:0] s_blend_green = '0;
    logic [CH_W-1:0] s_blend_blue  = '0;
    logic [CH_W-1:0] s_blend_alpha = '0;
    logic         m_valid;
    logic         m_ready       = 1'b0;
    logic [CH_W-1:0] m_out_red;
    logic [CH_W-1:0] m_out_green;
    logic [CH_W-1:0] m_out_blue;
    logic [CH_W-1:0] m_out_alpha;

    color_t      pending_colors[$];
    blend_case_t directed_cases[$];
    bit          idle_on        = 1'b1;
    int          pixels_sent    = 0;
    int          colors_checked = 0;
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          mode_hits[16];

    pixel_blend_mode_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_base_red    (s_base_red),
        .s_base_green  (s_base_green),
        .s_base_blue   (s_base_blue),
        .s_base_alpha  (s_base_alpha),
        .s_blend_red   (s_blend_red),
        .s_blend_green (s_blend_green),
        .s_blend_blue  (s_blend_blue),
        .s_blend_alpha (s_blend_alpha),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_red     (m_out_red),
        .m_out_green   (m_out_green),
        .m_out_blue    (m_out_blue),
        .m_out_alpha   (m_out_alpha)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("pixel_blend_mode_unit test failed");
            $finish;
        end
    end

    function automatic color_t rgba(input int r, input int g, input int b, input int a);
        color_t c;
        c[CH_RED]   = r[CH_W-1:0];
        c[CH_GREEN] = g[CH_W-1:0];
        c[CH_BLUE]  = b[CH_W-1:0];
        c[ALPHA_CH] = a[CH_W-1:0];
        return c;
    endfunction

    // Predict the blended color of one pixel, channel by channel
    function automatic color_t blend_pixel(input pixel_t p);
        color_t res;
        longint x;
        longint y;
        longint w;
        longint v;
        w = longint'(p.blend[ALPHA_CH]);
        for (int i = 0; i < NUM_CH; i++) begin
            x = longint'(p.base[i]);
            y = longint'(p.blend[i]);
            case (p.func)
                FUNC_IGNORE:   v = x;
                FUNC_ADD:      v = (x + y > FX_ONE) ? FX_ONE : x + y;
                FUNC_SUBTRACT: v = x - y;
                FUNC_MULTIPLY: v = (x * y) / FX_ONE;
                FUNC_MORPH:    v = x + ((y - x) * FX_HALF) / FX_ONE;
                FUNC_BLEND:    v = (i == ALPHA_CH) ? x : x + ((y - x) * w) / FX_ONE;
                FUNC_INVERT: begin
                    v = (i == ALPHA_CH) ? x
                        : ((FX_ONE - x) * w + x * (FX_ONE - w)) / FX_ONE;
                end
                FUNC_MIN:      v = (x < y) ? x : y;
                FUNC_MAX:      v = (x > y) ? x : y;
                default:       v = y;
            endcase
            // Saturate to the channel width
            if (v < 0)
                v = 0;
            else if (v > FX_TOP)
                v = FX_TOP;
            res[i] = v[CH_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [CH_W-1:0] rand_channel();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return CH_W'($urandom_range(0, 4096));
        if (sel < 7) begin
            case ($urandom_range(0, 4))
                0:       return 13'd0;
                1:       return 13'd1;
                2:       return 13'd4095;
                3:       return 13'd4096;
                default: return 13'd8191;
            endcase
        end
        return CH_W'($urandom_range(0, 8191));
    endfunction

    function automatic pixel_t rand_pixel();
        pixel_t p;
        p.func = 4'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 9)
                                                 : $urandom_range(10, 15));
        for (int i = 0; i < NUM_CH; i++) begin
            p.base[i]  = rand_channel();
            p.blend[i] = rand_channel();
        end
        return p;
    endfunction

    function automatic void add_case(input logic [3:0] func, input color_t base,
                                     input color_t blend, input logic has_want,
                                     input color_t want);
        blend_case_t c;
        c.pix.func  = func;
        c.pix.base  = base;
        c.pix.blend = blend;
        c.has_want  = has_want;
        c.want      = want;
        directed_cases.push_back(c);
    endfunction

    // Present one pixel, after a random gap when idling is on, and hold it until accepted
    task automatic send_pixel(input pixel_t p, input logic has_want, input color_t want);
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_func        <= p.func;
        s_base_red    <= p.base[CH_RED];
        s_base_green  <= p.base[CH_GREEN];
        s_base_blue   <= p.base[CH_BLUE];
        s_base_alpha  <= p.base[ALPHA_CH];
        s_blend_red   <= p.blend[CH_RED];
        s_blend_green <= p.blend[CH_GREEN];
        s_blend_blue  <= p.blend[CH_BLUE];
        s_blend_alpha <= p.blend[ALPHA_CH];
        do @(posedge aclk); while (!s_ready);
        pending_colors.push_back(has_want ? want : blend_pixel(p));
        mode_hits[p.func]++;
        pixels_sent++;
    endtask

    // Hold off the sender until the pipeline has emptied
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_colors.size() != 0);
    endtask

    // Result side: random stalls, compare each transaction with the oldest prediction
    initial begin
        int     stall;
        color_t got;
        color_t want;
        string  ch_name[NUM_CH];
        ch_name = '{"out_red", "out_green", "out_blue", "out_alpha"};
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = idle_on ? $urandom_range(0, 7) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got = {m_out_alpha, m_out_blue, m_out_green, m_out_red};
            if (pending_colors.size() == 0) begin
                $error("result with no pixel outstanding: %0d %0d %0d %0d",
                       m_out_red, m_out_green, m_out_blue, m_out_alpha);
                mismatch_count++;
            end else begin
                want = pending_colors.pop_front();
                colors_checked++;
                for (int i = 0; i < NUM_CH; i++) begin
                    if (got[i] !== want[i]) begin
                        $error("%s: expected %0d, got %0d", ch_name[i], want[i], got[i]);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial begin
        int modes_seen;
        // Directed cases: extremes, every mode, clamps, weight extremes, unused codes
        add_case(FUNC_REPLACE, rgba(0, 0, 0, 0), rgba(4096, 4096, 4096, 4096),
                 1'b1, rgba(4096, 4096, 4096, 4096));
        add_case(FUNC_IGNORE, rgba(4096, 8191, 0, 4096), rgba(0, 0, 0, 0),
                 1'b1, rgba(4096, 8191, 0, 4096));
        add_case(FUNC_ADD, rgba(4096, 4096, 4096, 4096), rgba(4096, 4096, 4096, 4096),
                 1'b1, rgba(4096, 4096, 4096, 4096));
        add_case(FUNC_ADD, rgba(8191, 8191, 0, 1), rgba(8191, 0, 0, 4095),
                 1'b1, rgba(4096, 4096, 0, 4096));
        add_case(FUNC_SUBTRACT, rgba(0, 100, 4096, 8191), rgba(4096, 4096, 0, 0),
                 1'b1, rgba(0, 0, 4096, 8191));
        add_case(FUNC_MULTIPLY, rgba(4096, 4096, 4096, 4096), rgba(4096, 4096, 4096, 4096),
                 1'b1, rgba(4096, 4096, 4096, 4096));
        add_case(FUNC_MULTIPLY, rgba(8191, 8191, 8191, 8191), rgba(8191, 8191, 8191, 8191),
                 1'b1, rgba(8191, 8191, 8191, 8191));
        add_case(FUNC_MULTIPLY, rgba(4096, 2048, 1, 8191), rgba(0, 2, 4095, 4096),
                 1'b1, rgba(0, 1, 0, 8191));
        add_case(FUNC_MORPH, rgba(0, 0, 0, 0), rgba(4096, 4096, 4096, 4096),
                 1'b1, rgba(2048, 2048, 2048, 2048));
        add_case(FUNC_MORPH, rgba(4096, 1, 3, 8191), rgba(0, 0, 0, 0), 1'b0, '0);
        add_case(FUNC_BLEND, rgba(100, 200, 300, 400), rgba(4096, 4096, 4096, 0),
                 1'b1, rgba(100, 200, 300, 400));
        add_case(FUNC_BLEND, rgba(100, 200, 300, 400), rgba(0, 8191, 4096, 4096),
                 1'b1, rgba(0, 8191, 4096, 400));
        add_case(FUNC_BLEND, rgba(0, 4096, 8191, 0), rgba(4096, 0, 0, 8191), 1'b0, '0);
        add_case(FUNC_BLEND, rgba(1000, 3000, 50, 4096), rgba(3000, 1000, 4000, 1365),
                 1'b0, '0);
        add_case(FUNC_INVERT, rgba(0, 4096, 1234, 77), rgba(9, 9, 9, 0),
                 1'b1, rgba(0, 4096, 1234, 77));
        add_case(FUNC_INVERT, rgba(0, 4096, 1234, 77), rgba(0, 0, 0, 4096),
                 1'b1, rgba(4096, 0, 2862, 77));
        add_case(FUNC_INVERT, rgba(8191, 2048, 100, 3000), rgba(0, 0, 0, 8191), 1'b0, '0);
        add_case(FUNC_INVERT, rgba(500, 3500, 4096, 0), rgba(0, 0, 0, 2048), 1'b0, '0);
        add_case(FUNC_MIN, rgba(0, 4096, 8191, 100), rgba(4096, 0, 8190, 100),
                 1'b1, rgba(0, 0, 8190, 100));
        add_case(FUNC_MAX, rgba(0, 4096, 8191, 100), rgba(4096, 0, 8190, 100),
                 1'b1, rgba(4096, 4096, 8191, 100));
        for (int code = FUNC_MAX + 1; code < 16; code++) begin
            add_case(4'(code), rgba(4096, 8191, 0, 4096), rgba(1, 2, 3, 4),
                     1'b1, rgba(1, 2, 3, 4));
        end

        // Hold reset, then release it ahead of the first pixel
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_cases[i])
            send_pixel(directed_cases[i].pix, directed_cases[i].has_want,
                       directed_cases[i].want);
        drain_pipeline();

        // Random pixels in segments, some with idling and some back to back
        for (int n = 0; n < RAND_PIXELS; n++) begin
            if (n % 64 == 0) begin
                if (n > 0 && $urandom_range(0, 3) == 0)
                    drain_pipeline();
                idle_on = ($urandom_range(0, 3) != 0);
            end
            send_pixel(rand_pixel(), 1'b0, '0);
        end
        s_valid <= 1'b0;

        // Wait out the tail and catch any stray results
        while (pending_colors.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        modes_seen = 0;
        foreach (mode_hits[i])
            if (mode_hits[i] > 0) modes_seen++;
        $display("Sent %0d pixels (%0d directed) over %0d of 16 mode codes, checked %0d colors.",
                 pixels_sent, directed_cases.size(), modes_seen, colors_checked);
        $display("Mismatches: %0d", mismatch_count);
        if (mismatch_count == 0)
            $display("pixel_blend_mode_unit test passed");
        else
            $display("pixel_blend_mode_unit test failed");
        $finish;
    end

endmodule
